@@ src/gcg_pkg.sv @@
// gcg_pkg: shared constants, types and register codes for the geometric countdown generator.
// No dependencies.
package gcg_pkg;

	localparam int unsigned LOG_FRAC_BITS_DEF   = 26;
	localparam int unsigned SCALE_FRAC_BITS_DEF = 16;

	localparam int unsigned LCG_W   = 48;
	localparam int unsigned SCALE_W = 40;
	localparam int unsigned COUNT_W = 31;
	localparam int unsigned N_W     = 6;	// leading-zero count, 0..47, plus one fits

	// LCG multiplier 0x5DEECE66D split into a 32-bit low part and a 3-bit high part
	localparam logic [31:0] LCG_MUL_LO = 32'hDEECE66D;
	localparam logic [2:0]  LCG_MUL_HI = 3'h5;
	localparam logic [47:0] LCG_INC    = 48'hB;
	localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
	localparam logic [30:0] COUNT_MAX  = 31'h7FFFFFFF;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_SEED   = 2'd1,
		REG_SCALE  = 2'd2
	} gcg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LCG_LO,
		ST_LCG_HI,
		ST_NORM,
		ST_LOG,
		ST_LN_LO,
		ST_LN_HI,
		ST_MUL,
		ST_FIN
	} gcg_state_t;

	// head of the job queue as seen by the back end
	typedef struct packed {
		logic valid;
		logic draw;	// 1: random countdown, 0: maximum countdown
	} gcg_job_t;

endpackage

@@ src/gcg_front.sv @@
// gcg_front: accepts request items, classifies them and queues jobs for the back end.
// Depends on gcg_pkg.
module gcg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              request,
	input  logic              enable,
	input  logic              pop,
	output gcg_pkg::gcg_job_t job
);

	logic       draw_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;

	assign in_stall = (cnt_q == 2'd2);
	// items without a request are taken and dropped
	assign push     = in_valid && !in_stall && request;
	assign do_pop   = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			draw_mem[wr_ptr_q] <= enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

	assign job.valid = (cnt_q != 2'd0);
	assign job.draw  = draw_mem[rd_ptr_q];

endmodule

@@ src/gcg_back.sv @@
// gcg_back: steps the LCG, forms -ln(u) iteratively, scales, saturates and holds the result.
// Depends on gcg_pkg.
module gcg_back #(
	parameter int unsigned LOG_FRAC_BITS   = gcg_pkg::LOG_FRAC_BITS_DEF,
	parameter int unsigned SCALE_FRAC_BITS = gcg_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcg_pkg::gcg_job_t             job,
	output logic                          pop,
	input  logic                          seed_load,
	input  logic [gcg_pkg::LCG_W-1:0]     seed,
	input  logic [gcg_pkg::SCALE_W-1:0]   scale,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gcg_pkg::COUNT_W-1:0]   countdown
);

	localparam int unsigned SH   = LOG_FRAC_BITS + SCALE_FRAC_BITS;
	localparam int unsigned IT_W = $clog2(LOG_FRAC_BITS);

	gcg_pkg::gcg_state_t state_q, state_d;

	logic [47:0]              x_q;	// generator state
	logic [47:0]              lo_q;
	logic [47:0]              m_q;
	logic [gcg_pkg::N_W-1:0]  n_q;
	logic [31:0]              z_q;
	logic [LOG_FRAC_BITS-1:0] f_q;
	logic [IT_W-1:0]          it_q;
	logic [63:0]              l_q;
	logic [1:0]               k_q;
	logic [127:0]             acc_q;
	logic                     out_valid_q;
	logic [30:0]              countdown_q;

	logic        out_free;
	logic [31:0] hp;
	logic [47:0] x_next;
	logic [63:0] sq;
	logic [32:0] sq_t;
	logic [63:0] t64;
	logic [63:0] ln_pp;
	logic [63:0] s64;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [127:0] mul_sh;
	logic        sat;
	logic [30:0] q31;

	assign out_free = !out_valid_q || !out_stall;

	// LCG: low 48 bits of x * M + inc, two partial products
	assign hp     = {16'b0, x_q[15:0]} * {29'b0, gcg_pkg::LCG_MUL_HI}
	              + {16'b0, x_q[47:32]} * {16'b0, gcg_pkg::LCG_MUL_LO[15:0]};
	assign x_next = lo_q + {hp[15:0], 32'b0};

	// squaring step of the log2 loop
	assign sq   = {32'b0, z_q} * {32'b0, z_q};
	assign sq_t = sq[63:31];

	// -log2(u) and the ln 2 partial products
	assign t64   = (64'(n_q + gcg_pkg::N_W'(1)) << LOG_FRAC_BITS) - 64'(f_q);
	assign ln_pp = (state_q == gcg_pkg::ST_LN_LO)
	             ? {32'b0, t64[31:0]} * {32'b0, gcg_pkg::LN2_Q32}
	             : {32'b0, t64[63:32]} * {32'b0, gcg_pkg::LN2_Q32};

	// scale multiply: one 32x32 partial product a cycle
	assign s64   = 64'(scale);
	assign mul_a = k_q[1] ? l_q[63:32] : l_q[31:0];
	assign mul_b = k_q[0] ? s64[63:32] : s64[31:0];
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	always_comb begin
		case (2'(k_q[1]) + 2'(k_q[0]))
			2'd0:    mul_sh = 128'(mul_p);
			2'd1:    mul_sh = 128'(mul_p) << 32;
			default: mul_sh = 128'(mul_p) << 64;
		endcase
	end

	assign q31 = acc_q[SH +: 31];
	assign sat = (|(acc_q >> (SH + 31))) || (q31 == gcg_pkg::COUNT_MAX);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			gcg_pkg::ST_IDLE: begin
				if (job.valid) begin
					if (!job.draw) begin
						if (out_free) begin
							pop = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						state_d = gcg_pkg::ST_LCG_LO;
					end
				end
			end
			gcg_pkg::ST_LCG_LO: state_d = gcg_pkg::ST_LCG_HI;
			gcg_pkg::ST_LCG_HI: begin
				state_d = (x_next == 48'b0) ? gcg_pkg::ST_LCG_LO : gcg_pkg::ST_NORM;
			end
			gcg_pkg::ST_NORM: begin
				if (m_q[47]) begin
					state_d = gcg_pkg::ST_LOG;
				end
			end
			gcg_pkg::ST_LOG: begin
				if (it_q == IT_W'(LOG_FRAC_BITS - 1)) begin
					state_d = gcg_pkg::ST_LN_LO;
				end
			end
			gcg_pkg::ST_LN_LO: state_d = gcg_pkg::ST_LN_HI;
			gcg_pkg::ST_LN_HI: state_d = gcg_pkg::ST_MUL;
			gcg_pkg::ST_MUL: begin
				if (k_q == 2'd3) begin
					state_d = gcg_pkg::ST_FIN;
				end
			end
			gcg_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = gcg_pkg::ST_IDLE;
				end
			end
			default: state_d = gcg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// generator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= 48'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_load) begin
				x_q <= seed;
			end else if (state_q == gcg_pkg::ST_LCG_HI) begin
				x_q <= x_next;
			end
			if (state_q == gcg_pkg::ST_IDLE && job.valid && !job.draw && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_q == gcg_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gcg_pkg::ST_IDLE: begin
				if (job.valid && !job.draw && out_free) begin
					countdown_q <= gcg_pkg::COUNT_MAX;
				end
			end
			gcg_pkg::ST_LCG_LO: begin
				lo_q <= 48'({32'b0, x_q[31:0]} * {32'b0, gcg_pkg::LCG_MUL_LO})
				      + gcg_pkg::LCG_INC;
			end
			gcg_pkg::ST_LCG_HI: begin
				m_q <= x_next;
				n_q <= '0;
			end
			gcg_pkg::ST_NORM: begin
				if (m_q[47]) begin
					z_q  <= m_q[47:16];
					f_q  <= '0;
					it_q <= '0;
				end else if (m_q[47:40] == 8'b0) begin
					m_q <= m_q << 8;
					n_q <= n_q + gcg_pkg::N_W'(8);
				end else begin
					m_q <= m_q << 1;
					n_q <= n_q + gcg_pkg::N_W'(1);
				end
			end
			gcg_pkg::ST_LOG: begin
				z_q  <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				f_q  <= {f_q[LOG_FRAC_BITS-2:0], sq_t[32]};
				it_q <= it_q + IT_W'(1);
			end
			gcg_pkg::ST_LN_LO: begin
				l_q <= {32'b0, ln_pp[63:32]};
			end
			gcg_pkg::ST_LN_HI: begin
				l_q   <= l_q + ln_pp;
				k_q   <= 2'd0;
				acc_q <= '0;
			end
			gcg_pkg::ST_MUL: begin
				acc_q <= acc_q + mul_sh;
				k_q   <= k_q + 2'd1;
			end
			gcg_pkg::ST_FIN: begin
				if (out_free) begin
					countdown_q <= sat ? gcg_pkg::COUNT_MAX : q31 + 31'd1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign countdown = countdown_q;

endmodule

@@ src/geometric_countdown_generator.sv @@
// geometric_countdown_generator: top level, configuration registers, front and back ends.
// Depends on gcg_pkg, gcg_front, gcg_back.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------
//   in      | in_valid / in_stall    | request (1b)
//   out     | out_valid / out_stall  | countdown (31b)
//   cfg     | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (48b)
//
// A request with sampling disabled is queued; its maximum countdown is registered when the
// back end is idle and the output is free. A random draw steps the LCG (again if it hits zero),
// normalizes, runs the serial squaring loop of the log2 unit, multiplies by ln 2 and by the
// scale and saturates; the squaring loop dominates. A busy back end or held result delays it.
// Reset clears control, configuration and generator state; datapath registers load before use.
// A two-entry job queue keeps taking items while a result waits on out_stall, until it is full.
// Items with request low are accepted and give no result.
module geometric_countdown_generator #(
	parameter int unsigned LOG_FRAC_BITS   = gcg_pkg::LOG_FRAC_BITS_DEF,
	parameter int unsigned SCALE_FRAC_BITS = gcg_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        request,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gcg_pkg::COUNT_W-1:0] countdown,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [gcg_pkg::LCG_W-1:0]   cfg_data
);

	logic                          enable_q;
	logic [gcg_pkg::SCALE_W-1:0]   scale_q;
	logic                          cfg_wr;
	logic                          seed_load;
	logic                          pop;
	gcg_pkg::gcg_job_t             job;

	// registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// seed writes go straight into the generator state in the back end
	assign seed_load = cfg_wr && (cfg_index == gcg_pkg::REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			scale_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				gcg_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				gcg_pkg::REG_SCALE:  scale_q  <= cfg_data[gcg_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	gcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.request  (request),
		.enable   (enable_q),
		.pop      (pop),
		.job      (job)
	);

	gcg_back #(
		.LOG_FRAC_BITS   (LOG_FRAC_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.pop       (pop),
		.seed_load (seed_load),
		.seed      (cfg_data),
		.scale     (scale_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.countdown (countdown)
	);

endmodule

@@ src/gcg_checker.sv @@
// gcg_checker: port-level assertions for geometric_countdown_generator, bound to the top.
// Depends on gcg_pkg.
module gcg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [gcg_pkg::COUNT_W-1:0] countdown,
	input logic                        cfg_ready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(countdown))
		else $error("stalled result changed");

	// countdown is never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> countdown != '0)
		else $error("zero countdown");

	// queue only fills after an accepted item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall without accepted item");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind geometric_countdown_generator gcg_checker u_gcg_checker (.*);
